// File: rtl/gpio_expander_register_block_assert.svh
// Assertion macros for the I/O expander register block.
// Included by the checker module; needs nothing else.
`ifndef GPIO_EXPANDER_REGISTER_BLOCK_ASSERT_SVH
`define GPIO_EXPANDER_REGISTER_BLOCK_ASSERT_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define GXR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define GXR_ASSERT_CLK(name, prop, msg) \
  `GXR_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/gpio_exp_pkg.sv
// Shared codes and constants of the I/O expander register block.
// No dependencies.
`default_nettype none

package gpio_exp_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned AddrW = 7;

  localparam logic [OpW-1:0] OpRead   = 2'd0;
  localparam logic [OpW-1:0] OpWrite  = 2'd1;
  localparam logic [OpW-1:0] OpSample = 2'd2;

  localparam logic [AddrW-1:0] AddrP0In    = 7'h00;
  localparam logic [AddrW-1:0] AddrP1In    = 7'h01;
  localparam logic [AddrW-1:0] AddrP0Out   = 7'h02;
  localparam logic [AddrW-1:0] AddrP1Out   = 7'h03;
  localparam logic [AddrW-1:0] AddrP0Dir   = 7'h04;
  localparam logic [AddrW-1:0] AddrP1Dir   = 7'h05;
  localparam logic [AddrW-1:0] AddrP0Mask  = 7'h06;
  localparam logic [AddrW-1:0] AddrP1Mask  = 7'h07;
  localparam logic [AddrW-1:0] AddrChipId  = 7'h10;
  localparam logic [AddrW-1:0] AddrGlobCtl = 7'h11;
  localparam logic [AddrW-1:0] AddrP0Mode  = 7'h12;
  localparam logic [AddrW-1:0] AddrP1Mode  = 7'h13;

  localparam logic [7:0] ChipId   = 8'h23;
  localparam int unsigned PpBit   = 4;

endpackage

`default_nettype wire

// File: rtl/gpio_expander_register_block.sv
// Top level of the 16-pin I/O expander register block.
// Depends on gpio_exp_pkg.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------
//   in      | input     | in_valid_i / in_ready_o | opcode, reg_addr, write_data, pins
//   out     | output    | out_valid_o/out_ready_i | read_data, pin_drive, pin_enable, irq
//
// One item per cycle while in_ready_o is high: the register update and the result are
// computed in the cycle the item is accepted and then registered for the output.
// A result register plus a one-entry skid buffer let the block take another item
// while a result waits; input ready drops only when both are full.
// Reset puts all state registers at their power-on values at once; no clearing pass.
`default_nettype none

module gpio_expander_register_block #(
  parameter int unsigned PIN_COUNT = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [gpio_exp_pkg::OpW-1:0]   opcode_i,
  input  wire logic [gpio_exp_pkg::AddrW-1:0] reg_addr_i,
  input  wire logic [7:0]                     write_data_i,
  input  wire logic [15:0]                    pin_levels_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [7:0]                          read_data_o,
  output logic [15:0]                         pin_drive_o,
  output logic [15:0]                         pin_enable_o,
  output logic                                irq_n_o
);
  import gpio_exp_pkg::*;

  localparam logic [15:0] PinMask = 16'((32'd1 << PIN_COUNT) - 32'd1);

  typedef struct packed {
    logic [7:0]  rd;
    logic [15:0] drive;
    logic [15:0] enable;
    logic        irq_n;
  } result_t;

  // Architectural state.
  logic [15:0]          latch_q, latch_d;
  logic [15:0]          dir_q, dir_d;
  logic [15:0]          mask_q, mask_d;
  logic [15:0]          mode_q, mode_d;
  logic [7:0]           gctl_q, gctl_d;
  logic [PIN_COUNT-1:0] last_q, last_d;
  logic [1:0]           flags_q, flags_d;

  // Output register and skid entry.
  result_t res_d, out_q, skd_q;
  logic    out_valid_q, skd_valid_q;

  logic        push, pop, out_free;
  logic [15:0] last_w, changed, outs, en;

  assign in_ready_o = ~skd_valid_q;
  assign push       = in_valid_i & in_ready_o;
  assign pop        = out_valid_q & out_ready_i;
  assign out_free   = ~out_valid_q | pop;
  assign last_w     = 16'(last_q);

  always_comb begin
    latch_d    = latch_q;
    dir_d      = dir_q;
    mask_d     = mask_q;
    mode_d     = mode_q;
    gctl_d     = gctl_q;
    last_d     = last_q;
    flags_d    = flags_q;
    res_d.rd   = 8'h00;
    changed    = 16'h0000;
    if (push) begin
      unique case (opcode_i)
        OpRead: begin
          unique case (reg_addr_i)
            AddrP0In: begin
              res_d.rd   = last_w[7:0];
              flags_d[0] = 1'b0;
            end
            AddrP1In: begin
              res_d.rd   = last_w[15:8];
              flags_d[1] = 1'b0;
            end
            AddrP0Out:   res_d.rd = latch_q[7:0];
            AddrP1Out:   res_d.rd = latch_q[15:8];
            AddrP0Dir:   res_d.rd = dir_q[7:0];
            AddrP1Dir:   res_d.rd = dir_q[15:8];
            AddrP0Mask:  res_d.rd = mask_q[7:0];
            AddrP1Mask:  res_d.rd = mask_q[15:8];
            AddrChipId:  res_d.rd = ChipId;
            AddrGlobCtl: res_d.rd = gctl_q;
            AddrP0Mode:  res_d.rd = mode_q[7:0];
            AddrP1Mode:  res_d.rd = mode_q[15:8];
            default:     res_d.rd = 8'h00;
          endcase
        end
        OpWrite: begin
          unique case (reg_addr_i)
            AddrP0Out:   latch_d[7:0]  = write_data_i;
            AddrP1Out:   latch_d[15:8] = write_data_i;
            AddrP0Dir:   dir_d[7:0]    = write_data_i;
            AddrP1Dir:   dir_d[15:8]   = write_data_i;
            AddrP0Mask:  mask_d[7:0]   = write_data_i;
            AddrP1Mask:  mask_d[15:8]  = write_data_i;
            AddrGlobCtl: gctl_d        = write_data_i;
            AddrP0Mode:  mode_d[7:0]   = write_data_i;
            AddrP1Mode:  mode_d[15:8]  = write_data_i;
            default:     ;
          endcase
        end
        OpSample: begin
          // Only unmasked input pins that exist can raise a port flag.
          changed    = (pin_levels_i ^ last_w) & dir_q & ~mask_q & PinMask;
          flags_d[0] = flags_q[0] | (|changed[7:0]);
          flags_d[1] = flags_q[1] | (|changed[15:8]);
          last_d     = pin_levels_i[PIN_COUNT-1:0];
        end
        default: ;
      endcase
    end

    // Pins in LED mode are never driven. Open-drain P0 pins are enabled
    // only while their latch bit is low.
    outs = ~dir_d & mode_d & PinMask;
    if (gctl_d[PpBit]) begin
      en = outs;
    end else begin
      en = outs & ~{8'h00, latch_d[7:0]};
    end
    res_d.enable = en;
    res_d.drive  = latch_d & en;
    res_d.irq_n  = ~|flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      dir_q   <= '1;
      mask_q  <= '1;
      mode_q  <= '1;
      gctl_q  <= '0;
      last_q  <= '0;
      flags_q <= '0;
    end else if (push) begin
      latch_q <= latch_d;
      dir_q   <= dir_d;
      mask_q  <= mask_d;
      mode_q  <= mode_d;
      gctl_q  <= gctl_d;
      last_q  <= last_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skd_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        if (skd_valid_q) begin
          out_valid_q <= 1'b1;
          skd_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push;
        end
      end else if (push) begin
        skd_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skd_valid_q) begin
        out_q <= skd_q;
      end else if (push) begin
        out_q <= res_d;
      end
    end else if (push) begin
      skd_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = out_q.rd;
  assign pin_drive_o  = out_q.drive;
  assign pin_enable_o = out_q.enable;
  assign irq_n_o      = out_q.irq_n;

endmodule

`default_nettype wire

// File: rtl/gpio_exp_checker.sv
// Port-level assertions for the I/O expander register block, bound to its top level.
// Depends on gpio_exp_pkg and gpio_expander_register_block_assert.svh.
`default_nettype none

`include "gpio_expander_register_block_assert.svh"

module gpio_exp_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic [gpio_exp_pkg::OpW-1:0]   opcode_i,
  input wire logic [gpio_exp_pkg::AddrW-1:0] reg_addr_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [7:0]                     read_data_o,
  input wire logic [15:0]                    pin_drive_o,
  input wire logic [15:0]                    pin_enable_o,
  input wire logic                           irq_n_o
);
  import gpio_exp_pkg::*;

  logic in_acc, id_read, non_read;

  assign in_acc   = in_valid_i & in_ready_o;
  assign id_read  = in_acc & (opcode_i == OpRead) & (reg_addr_i == AddrChipId);
  assign non_read = in_acc & (opcode_i != OpRead);

  // A pending result must not vanish before it is taken.
  `GXR_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o,
                  "result dropped while stalled")

  // The input side only stalls when a result is already waiting.
  `GXR_ASSERT_CLK(a_stall_needs_result, !in_ready_o |-> out_valid_o,
                  "input stalled with no result pending")

  // An item that finds the output empty shows up next cycle; the chip ID is fixed.
  `GXR_ASSERT_CLK(a_chip_id, id_read && !out_valid_o |=> out_valid_o && read_data_o == ChipId,
                  "chip ID read returned a wrong value")

  `GXR_ASSERT_CLK(a_nonread_zero, non_read && !out_valid_o |=> read_data_o == 8'h00,
                  "non-read item returned nonzero read data")

  // A pin can only be driven high where its driver is enabled.
  `GXR_ASSERT_CLK(a_drive_in_enable, out_valid_o |-> (pin_drive_o & ~pin_enable_o) == 16'h0000,
                  "pin driven without enable")

endmodule

bind gpio_expander_register_block gpio_exp_checker u_gpio_exp_checker (.*);

`default_nettype wire

// File: bench/tb_gpio_expander_register_block.sv
// Self-checking testbench for the 16-pin I/O expander register block.
// Drives register reads, writes and pin samples and checks every reply.
// Depends on gpio_exp_pkg and gpio_expander_register_block.
`timescale 1ns / 100ps

module tb_gpio_expander_register_block;
  import gpio_exp_pkg::*;

  localparam int unsigned PinCount = 16;
  localparam logic [31:0] PinMaskWide = (32'h1 << PinCount) - 32'h1;
  localparam logic [15:0] PinMask = PinMaskWide[15:0];
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam logic [AddrW-1:0] AddrUnknown = 7'h7F;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned ItemsPerPhase = 175;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
    logic [15:0]      levels;
    logic             drain;
  } bus_access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] pin_drive;
    logic [15:0] pin_enable;
    logic        irq_n;
  } pin_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [OpW-1:0] opcode = OpRead;
  logic [AddrW-1:0] reg_addr = '0;
  logic [7:0] write_data = '0;
  logic [15:0] pin_levels = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [7:0] read_data;
  logic [15:0] pin_drive;
  logic [15:0] pin_enable;
  logic irq_n;

  bus_access_t bus_accesses[$];
  pin_reply_t register_replies[$];
  bus_access_t in_flight;
  int unsigned send_idle = 20;
  int unsigned recv_idle = 60;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic [15:0] gen_levels = '0;

  // Shadow copy of the register file.
  logic [7:0] out_byte [2] = '{8'h00, 8'h00};
  logic [7:0] dir_byte [2] = '{8'hFF, 8'hFF};
  logic [7:0] mask_byte [2] = '{8'hFF, 8'hFF};
  logic [7:0] mode_byte [2] = '{8'hFF, 8'hFF};
  logic [7:0] glob_ctl = 8'h00;
  logic [15:0] last_lv = 16'h0000;
  logic [1:0] port_flags = 2'b00;

  gpio_expander_register_block #(
    .PIN_COUNT(PinCount)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .opcode_i    (opcode),
    .reg_addr_i  (reg_addr),
    .write_data_i(write_data),
    .pin_levels_i(pin_levels),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .read_data_o (read_data),
    .pin_drive_o (pin_drive),
    .pin_enable_o(pin_enable),
    .irq_n_o     (irq_n)
  );

  always #1 clk = ~clk;

  task automatic exec_access(input bus_access_t acc);
    logic [7:0] rd;
    logic [15:0] lv;
    logic [15:0] armed;
    logic [15:0] changed;
    logic [15:0] latch;
    logic [15:0] en;
    pin_reply_t rep;
    rd = 8'h00;
    if (acc.op == OpRead) begin
      case (acc.addr)
        AddrP0In: begin
          rd = last_lv[7:0];
          port_flags[0] = 1'b0;
        end
        AddrP1In: begin
          rd = last_lv[15:8];
          port_flags[1] = 1'b0;
        end
        AddrP0Out:   rd = out_byte[0];
        AddrP1Out:   rd = out_byte[1];
        AddrP0Dir:   rd = dir_byte[0];
        AddrP1Dir:   rd = dir_byte[1];
        AddrP0Mask:  rd = mask_byte[0];
        AddrP1Mask:  rd = mask_byte[1];
        AddrChipId:  rd = ChipId;
        AddrGlobCtl: rd = glob_ctl;
        AddrP0Mode:  rd = mode_byte[0];
        AddrP1Mode:  rd = mode_byte[1];
        default:     rd = 8'h00;
      endcase
    end else if (acc.op == OpWrite) begin
      case (acc.addr)
        AddrP0Out:   out_byte[0] = acc.data;
        AddrP1Out:   out_byte[1] = acc.data;
        AddrP0Dir:   dir_byte[0] = acc.data;
        AddrP1Dir:   dir_byte[1] = acc.data;
        AddrP0Mask:  mask_byte[0] = acc.data;
        AddrP1Mask:  mask_byte[1] = acc.data;
        AddrGlobCtl: glob_ctl = acc.data;
        AddrP0Mode:  mode_byte[0] = acc.data;
        AddrP1Mode:  mode_byte[1] = acc.data;
        default: ;
      endcase
    end else if (acc.op == OpSample) begin
      lv = acc.levels & PinMask;
      armed = {dir_byte[1], dir_byte[0]} & ~{mask_byte[1], mask_byte[0]};
      changed = (lv ^ last_lv) & armed & PinMask;
      if (|changed[7:0]) port_flags[0] = 1'b1;
      if (|changed[15:8]) port_flags[1] = 1'b1;
      last_lv = lv;
    end
    latch = {out_byte[1], out_byte[0]};
    en = ~{dir_byte[1], dir_byte[0]} & {mode_byte[1], mode_byte[0]} & PinMask;
    // Open drain on P0: a pin is only driven while its latch holds a zero.
    if (!glob_ctl[PpBit]) en[7:0] = en[7:0] & ~latch[7:0];
    rep.read_data = rd;
    rep.pin_drive = latch & en;
    rep.pin_enable = en;
    rep.irq_n = ~|port_flags;
    register_replies.push_back(rep);
  endtask

  task automatic push_access(input logic [OpW-1:0] op, input logic [AddrW-1:0] addr,
                             input logic [7:0] data, input logic [15:0] levels,
                             input logic drain);
    bus_access_t acc;
    acc.op = op;
    acc.addr = addr;
    acc.data = data;
    acc.levels = levels;
    acc.drain = drain;
    bus_accesses.push_back(acc);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned i;
    int unsigned sel;
    logic [OpW-1:0] op;
    logic [AddrW-1:0] addr;
    logic [7:0] data;
    for (i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      op = (sel < 40) ? OpRead : (sel < 72) ? OpWrite : (sel < 97) ? OpSample : OpUnused;
      if ($urandom_range(99) < 85) begin
        case ($urandom_range(11))
          0:  addr = AddrP0In;
          1:  addr = AddrP1In;
          2:  addr = AddrP0Out;
          3:  addr = AddrP1Out;
          4:  addr = AddrP0Dir;
          5:  addr = AddrP1Dir;
          6:  addr = AddrP0Mask;
          7:  addr = AddrP1Mask;
          8:  addr = AddrChipId;
          9:  addr = AddrGlobCtl;
          10: addr = AddrP0Mode;
          default: addr = AddrP1Mode;
        endcase
      end else begin
        addr = 7'($urandom_range(127));
      end
      sel = $urandom_range(9);
      data = (sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom);
      // Single-pin toggles half of the time so that edges on armed pins stay frequent.
      if ($urandom_range(1)) gen_levels = gen_levels ^ (16'h1 << $urandom_range(15));
      else gen_levels = 16'($urandom);
      push_access(op, addr, data, gen_levels, $urandom_range(99) < 2);
    end
  endtask

  // Driver: holds an item until it is taken, then predicts its reply.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) exec_access(in_flight);
      if (!in_valid || in_ready) begin
        if (bus_accesses.size() != 0 && $urandom_range(99) >= send_idle &&
            !(bus_accesses[0].drain && register_replies.size() != 0)) begin
          in_flight = bus_accesses.pop_front();
          in_valid <= 1'b1;
          opcode <= in_flight.op;
          reg_addr <= in_flight.addr;
          write_data <= in_flight.data;
          pin_levels <= in_flight.levels;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each reply with the oldest prediction.
  always @(posedge clk or negedge rst_n) begin
    pin_reply_t got;
    pin_reply_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.read_data = read_data;
        got.pin_drive = pin_drive;
        got.pin_enable = pin_enable;
        got.irq_n = irq_n;
        if (register_replies.size() == 0) begin
          $display("%0t: reply with none pending: rd=%h drive=%h en=%h irq_n=%b",
                   $time, got.read_data, got.pin_drive, got.pin_enable, got.irq_n);
          fail_count++;
        end else begin
          want = register_replies.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected rd=%h drive=%h en=%h irq_n=%b,",
                     $time, want.read_data, want.pin_drive, want.pin_enable, want.irq_n,
                     " actual rd=%h drive=%h en=%h irq_n=%b",
                     got.read_data, got.pin_drive, got.pin_enable, got.irq_n);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("gpio_expander_register_block verification failed");
    $finish;
  end

  initial begin
    int unsigned phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Read-only and unknown registers, then the drive modes, then interrupts.
    push_access(OpRead, AddrChipId, 8'h00, 16'h0000, 1'b0);
    push_access(OpWrite, AddrChipId, 8'hFF, 16'hFFFF, 1'b0);
    push_access(OpRead, AddrChipId, 8'h00, 16'h0000, 1'b0);
    push_access(OpWrite, AddrP0In, 8'h5A, 16'h0000, 1'b0);
    push_access(OpRead, AddrP0In, 8'h00, 16'h0000, 1'b0);
    push_access(OpWrite, AddrUnknown, 8'hFF, 16'h0000, 1'b0);
    push_access(OpRead, AddrUnknown, 8'h00, 16'h0000, 1'b0);
    push_access(OpUnused, AddrUnknown, 8'hFF, 16'hFFFF, 1'b0);
    push_access(OpWrite, AddrP0Dir, 8'h00, 16'h0000, 1'b0);
    push_access(OpWrite, AddrP1Dir, 8'h00, 16'h0000, 1'b0);
    push_access(OpWrite, AddrP0Out, 8'hFF, 16'h0000, 1'b0);
    push_access(OpWrite, AddrP1Out, 8'hA5, 16'h0000, 1'b0);
    push_access(OpWrite, AddrGlobCtl, 8'hFF, 16'h0000, 1'b0);
    push_access(OpWrite, AddrP0Mode, 8'h00, 16'h0000, 1'b0);
    push_access(OpRead, AddrP0Mode, 8'h00, 16'h0000, 1'b0);
    push_access(OpWrite, AddrP0Mode, 8'hFF, 16'h0000, 1'b0);
    push_access(OpWrite, AddrGlobCtl, 8'h00, 16'h0000, 1'b0);
    push_access(OpWrite, AddrP0Dir, 8'hFF, 16'h0000, 1'b1);
    push_access(OpWrite, AddrP1Dir, 8'hFF, 16'h0000, 1'b0);
    push_access(OpWrite, AddrP0Mask, 8'h00, 16'h0000, 1'b0);
    push_access(OpWrite, AddrP1Mask, 8'h00, 16'h0000, 1'b0);
    push_access(OpSample, AddrP0In, 8'h00, 16'hFFFF, 1'b0);
    push_access(OpRead, AddrP0In, 8'h00, 16'h0000, 1'b0);
    push_access(OpRead, AddrP1In, 8'h00, 16'h0000, 1'b0);
    push_access(OpSample, AddrP0In, 8'h00, 16'h0000, 1'b0);
    push_access(OpRead, AddrGlobCtl, 8'h00, 16'h0000, 1'b0);
    gen_levels = 16'h0000;

    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 20 : (phase == 1) ? 60 : 0;
      recv_idle = (phase == 0) ? 60 : (phase == 1) ? 20 : 0;
      queue_random(ItemsPerPhase);
      while (bus_accesses.size() != 0 || in_valid) @(posedge clk);
    end

    while (register_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("gpio_expander_register_block verification clean");
    else $display("gpio_expander_register_block verification failed");
    $finish;
  end

endmodule
